>>> hdl/czdc_pkg.sv
// ============================================================================
// czdc_pkg
// shared constants of the zone delta-correlation prefetcher
// ============================================================================
package czdc_pkg;

    localparam int ZONE_SHIFT_W = 5;
    localparam int DEGREE_W     = 4;
    localparam int CFG_DATA_W   = 5;
    localparam int CFG_INDEX_W  = 1;
    localparam int MAX_RESULTS  = 8;

    localparam logic [ZONE_SHIFT_W-1:0] ZONE_SHIFT_RESET = 5'd12;
    localparam logic [DEGREE_W-1:0]     DEGREE_RESET     = 4'd5;

    localparam logic [CFG_INDEX_W-1:0] REG_ZONE_SHIFT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEGREE     = 1'b1;

endpackage

>>> hdl/czdc_front.sv
// ============================================================================
// czdc_front
// accepts accesses, drops hits and queues misses for the history engine
// ============================================================================
module czdc_front #(
    parameter int ADDRESS_BITS = 28,
    parameter int QUEUE_DEPTH  = 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [ADDRESS_BITS-1:0] s_miss_address,
    input  logic                    s_is_miss,
    output logic                    q_valid,
    input  logic                    q_ready,
    output logic [ADDRESS_BITS-1:0] q_address
);
    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic [ADDRESS_BITS-1:0] mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0]   cnt_reg;
    logic push, pop;

    assign s_ready   = cnt_reg != (PW+1)'(QUEUE_DEPTH);
    assign push      = s_valid && s_ready && s_is_miss;
    assign q_valid   = cnt_reg != '0;
    assign pop       = q_valid && q_ready;
    assign q_address = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= s_miss_address;
        end
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end
endmodule

>>> hdl/czdc_back.sv
// ============================================================================
// czdc_back
// history buffer walk, pair correlation and prefetch replay
// ============================================================================
module czdc_back #(
    parameter int ADDRESS_BITS  = 28,
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [czdc_pkg::ZONE_SHIFT_W-1:0]    zone_shift,
    input  logic [czdc_pkg::DEGREE_W-1:0]        degree,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  logic [ADDRESS_BITS-1:0]              q_address,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [ADDRESS_BITS-1:0]              m_prefetch_address,
    output logic                                 m_in_range,
    output logic                                 m_last
);
    import czdc_pkg::*;

    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int CW = HW + 1;
    localparam int DW = ADDRESS_BITS + 1;
    localparam int SW = $clog2(ADDRESS_BITS + 1) + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_FIND, S_READ, S_SCAN, S_PAIR, S_EMIT
    } state_t;

    logic [ADDRESS_BITS-1:0] haddr_mem [HISTORY_DEPTH];
    logic [DW-1:0]           hdelta_mem [HISTORY_DEPTH];

    state_t                  state_reg;
    logic [ADDRESS_BITS-1:0] addr_reg, cur_reg;
    logic [HW-1:0]           head_reg;
    logic [CW-1:0]           count_reg, age_reg;
    logic [DW-1:0]           delta_reg;
    // zone delta list, newest first
    logic [DW-1:0]           zd_reg [HISTORY_DEPTH];
    logic [CW-1:0]           n_reg, j_reg, match_reg, kidx_reg;
    logic [DEGREE_W-1:0]     k_reg, deg_reg;
    logic [ADDRESS_BITS-1:0] rd_addr_reg;
    logic [DW-1:0]           rd_delta_reg;
    logic                    out_valid_reg;
    logic [ADDRESS_BITS-1:0] out_addr_reg;
    logic                    out_range_reg, out_last_reg;

    logic [CW-1:0] slot_sum;
    logic [HW-1:0] slot;
    logic          zone_eq, rd_zone_eq;
    logic [SW-1:0] sh;
    logic [ADDRESS_BITS-1:0] nxt;
    logic [DEGREE_W-1:0]     deg_sat;

    assign sh = SW'(zone_shift);
    // slot of the entry with the given age, wrapped to the history depth
    assign slot_sum = CW'(head_reg) + CW'(HISTORY_DEPTH - 1) - age_reg;
    assign slot = (slot_sum >= CW'(HISTORY_DEPTH)) ? HW'(slot_sum - CW'(HISTORY_DEPTH))
                                                   : HW'(slot_sum);
    assign rd_zone_eq = (rd_addr_reg >> sh) == (addr_reg >> sh);
    assign zone_eq = rd_zone_eq;
    assign nxt = cur_reg + zd_reg[HW'(kidx_reg)][ADDRESS_BITS-1:0];
    assign deg_sat = (degree > DEGREE_W'(MAX_RESULTS)) ? DEGREE_W'(MAX_RESULTS) : degree;

    assign q_ready = state_reg == S_IDLE;
    assign m_valid = out_valid_reg;
    assign m_prefetch_address = out_addr_reg;
    assign m_in_range = out_range_reg;
    assign m_last = out_last_reg;

    always_ff @(posedge aclk) begin
        rd_addr_reg  <= haddr_mem[slot];
        rd_delta_reg <= hdelta_mem[slot];
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        addr_reg  <= q_address;
                        delta_reg <= '0;
                        age_reg   <= '0;
                        state_reg <= (count_reg == '0) ? S_PAIR : S_FIND;
                        n_reg     <= '0;
                    end
                end
                // wait for the registered read data, then compare
                S_FIND: begin
                    state_reg <= S_READ;
                end
                S_READ: begin
                    if (rd_zone_eq) begin
                        delta_reg <= DW'(addr_reg) - DW'(rd_addr_reg);
                        state_reg <= S_PAIR;
                    end else if (age_reg + 1'b1 == count_reg) begin
                        state_reg <= S_PAIR;
                    end else begin
                        age_reg   <= age_reg + 1'b1;
                        state_reg <= S_FIND;
                    end
                end
                S_PAIR: begin
                    if (n_reg == '0 && age_reg != {CW{1'b1}}) begin
                        // push the new entry, then gather zone deltas
                        haddr_mem[head_reg]  <= addr_reg;
                        hdelta_mem[head_reg] <= delta_reg;
                        head_reg  <= (head_reg == HW'(HISTORY_DEPTH - 1)) ? '0
                                                                          : head_reg + 1'b1;
                        if (count_reg != CW'(HISTORY_DEPTH)) begin
                            count_reg <= count_reg + 1'b1;
                        end
                        zd_reg[0] <= delta_reg;
                        n_reg     <= CW'(1);
                        age_reg   <= CW'(1);
                        j_reg     <= CW'(1);
                        state_reg <= S_SCAN;
                    end else begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (age_reg >= count_reg) begin
                        j_reg     <= CW'(1);
                        match_reg <= '0;
                        state_reg <= (n_reg < CW'(3)) ? S_IDLE : S_EMIT;
                        k_reg     <= '0;
                        deg_reg   <= deg_sat;
                        cur_reg   <= addr_reg;
                    end else if (age_reg[0] ^ j_reg[0]) begin
                        // registered read data of this entry is now valid
                        if (zone_eq) begin
                            zd_reg[HW'(n_reg)] <= rd_delta_reg;
                            n_reg <= n_reg + 1'b1;
                        end
                        age_reg <= age_reg + 1'b1;
                        j_reg   <= {CW{1'b0}} | CW'(~age_reg[0]);
                    end else begin
                        j_reg <= {CW{1'b0}} | CW'(~age_reg[0]);
                    end
                end
                S_EMIT: begin
                    if (match_reg == '0) begin
                        if (j_reg + 1'b1 >= n_reg) begin
                            state_reg <= S_IDLE;
                        end else if (zd_reg[HW'(j_reg+1'b1)] == zd_reg[1] &&
                                     zd_reg[HW'(j_reg)] == zd_reg[0]) begin
                            match_reg <= j_reg;
                            kidx_reg  <= j_reg - 1'b1;
                            if (deg_reg == '0) state_reg <= S_IDLE;
                        end else begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end else if (!out_valid_reg || m_ready) begin
                        cur_reg       <= nxt;
                        out_valid_reg <= 1'b1;
                        out_addr_reg  <= nxt;
                        out_range_reg <= (nxt != '0) && (nxt != {ADDRESS_BITS{1'b1}});
                        out_last_reg  <= k_reg + 1'b1 == deg_reg;
                        k_reg         <= k_reg + 1'b1;
                        kidx_reg      <= (kidx_reg == '0) ? match_reg - 1'b1
                                                          : kidx_reg - 1'b1;
                        if (k_reg + 1'b1 == deg_reg) state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> hdl/czone_delta_correlation_prefetcher_top.sv
// ============================================================================
// czone_delta_correlation_prefetcher_top
// zone delta-correlation prefetcher over a global history buffer
// ============================================================================
// Hits are dropped at the front; misses wait in a two-entry queue for the back
// engine. The engine reads the history through a registered memory read and
// waits for each entry's data. It finds the zone's newest entry, pushes the
// miss, gathers the zone deltas, searches for the matching pair and gives one
// prefetch result per cycle while the result channel is ready; a stall on the
// result channel holds the engine, which takes no new miss until it is done.
// No clearing pass is needed after reset.
module czone_delta_correlation_prefetcher_top #(
    parameter int ADDRESS_BITS  = 28,
    parameter int HISTORY_DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [czdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [czdc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ADDRESS_BITS-1:0]             s_miss_address,
    input  logic                                s_is_miss,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ADDRESS_BITS-1:0]             m_prefetch_address,
    output logic                                m_in_range,
    output logic                                m_last
);
    import czdc_pkg::*;

    logic [ZONE_SHIFT_W-1:0] zone_shift_reg;
    logic [DEGREE_W-1:0]     degree_reg;
    logic                    q_valid, q_ready;
    logic [ADDRESS_BITS-1:0] q_address;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_shift_reg <= ZONE_SHIFT_RESET;
            degree_reg     <= DEGREE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ZONE_SHIFT: zone_shift_reg <= cfg_data;
                REG_DEGREE:     degree_reg     <= cfg_data[DEGREE_W-1:0];
                default: ;
            endcase
        end
    end

    czdc_front #(.ADDRESS_BITS(ADDRESS_BITS)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_miss_address, .s_is_miss,
        .q_valid, .q_ready, .q_address
    );

    czdc_back #(.ADDRESS_BITS(ADDRESS_BITS), .HISTORY_DEPTH(HISTORY_DEPTH)) u_back (
        .aclk, .aresetn, .zone_shift(zone_shift_reg), .degree(degree_reg),
        .q_valid, .q_ready, .q_address,
        .m_valid, .m_ready, .m_prefetch_address, .m_in_range, .m_last
    );
endmodule

>>> hdl/czdc_checker.sv
// ============================================================================
// czdc_checker
// port-level checks of the prefetcher
// ============================================================================
module czdc_checker #(
    parameter int ADDRESS_BITS = 28
) (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic [ADDRESS_BITS-1:0] m_prefetch_address,
    input logic                    m_in_range
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prefetch_address))
        else $error("result dropped while stalled");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_prefetch_address == '0 |-> !m_in_range)
        else $error("zero address in range");
    a_top: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_prefetch_address == {ADDRESS_BITS{1'b1}} |-> !m_in_range)
        else $error("limit address in range");
endmodule

bind czone_delta_correlation_prefetcher_top czdc_checker #(.ADDRESS_BITS(ADDRESS_BITS))
    u_checker (.aclk, .aresetn, .m_valid, .m_ready, .m_prefetch_address, .m_in_range);
